>>> design/dcd_pkg.sv
// Shared types and constants for the double clap detector.
package dcd_pkg;

  // Detector phase, one-hot.
  typedef enum logic [4:0] {
    PH_IDLE        = 5'b00001,
    PH_FIRST_LOUD  = 5'b00010,
    PH_FIRST_QUIET = 5'b00100,
    PH_SECOND_LOUD = 5'b01000,
    PH_DONE        = 5'b10000
  } phase_t;

  // Phase codes as they appear on the result word.
  localparam logic [2:0] PHASE_CODE_IDLE        = 3'd0;
  localparam logic [2:0] PHASE_CODE_FIRST_LOUD  = 3'd1;
  localparam logic [2:0] PHASE_CODE_FIRST_QUIET = 3'd2;
  localparam logic [2:0] PHASE_CODE_SECOND_LOUD = 3'd3;
  localparam logic [2:0] PHASE_CODE_DONE        = 3'd4;

  // Register map: index = paddr[4:2].
  localparam int unsigned ADDR_BITS = 5;
  localparam logic [2:0] REG_SOUND_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_MIN_SPIKE_TIME  = 3'd1;
  localparam logic [2:0] REG_MAX_SPIKE_TIME  = 3'd2;
  localparam logic [2:0] REG_MIN_GAP_TIME    = 3'd3;
  localparam logic [2:0] REG_MAX_GAP_TIME    = 3'd4;

  localparam int unsigned SPAN_BITS = 16;
  localparam int unsigned THRESHOLD_RESET = 2048;
  localparam logic [SPAN_BITS-1:0] MIN_SPIKE_RESET = 16'd10;
  localparam logic [SPAN_BITS-1:0] MAX_SPIKE_RESET = 16'd200;
  localparam logic [SPAN_BITS-1:0] MIN_GAP_RESET   = 16'd50;
  localparam logic [SPAN_BITS-1:0] MAX_GAP_RESET   = 16'd1000;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    unique case (ph)
      PH_IDLE:        code = PHASE_CODE_IDLE;
      PH_FIRST_LOUD:  code = PHASE_CODE_FIRST_LOUD;
      PH_FIRST_QUIET: code = PHASE_CODE_FIRST_QUIET;
      PH_SECOND_LOUD: code = PHASE_CODE_SECOND_LOUD;
      PH_DONE:        code = PHASE_CODE_DONE;
      default:        code = PHASE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

>>> design/dcd_core.sv
// Phase tracker of the double clap detector: spike and gap timing checks.
module dcd_core #(
  parameter int SAMPLE_BITS = 12,
  parameter int TIME_BITS   = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step_en,
  input  logic                           restart,
  input  logic [SAMPLE_BITS-1:0]         sample,
  input  logic [TIME_BITS-1:0]           now,
  input  logic [SAMPLE_BITS-1:0]         level_threshold,
  input  logic [dcd_pkg::SPAN_BITS-1:0]  min_spike_time,
  input  logic [dcd_pkg::SPAN_BITS-1:0]  max_spike_time,
  input  logic [dcd_pkg::SPAN_BITS-1:0]  min_gap_time,
  input  logic [dcd_pkg::SPAN_BITS-1:0]  max_gap_time,
  output dcd_pkg::phase_t                phase_next
);

  dcd_pkg::phase_t        phase;
  logic [TIME_BITS-1:0]   start_time;
  logic [TIME_BITS-1:0]   start_time_next;
  logic [TIME_BITS-1:0]   stop_time;
  logic [TIME_BITS-1:0]   stop_time_next;
  logic                   loud;
  logic                   quiet;
  logic [TIME_BITS-1:0]   spike_span;
  logic [TIME_BITS-1:0]   gap_span;

  assign loud       = sample > level_threshold;
  assign quiet      = sample < level_threshold;
  // Differences wrap modulo 2^TIME_BITS.
  assign spike_span = now - start_time;
  assign gap_span   = now - stop_time;

  always_comb begin
    phase_next      = phase;
    start_time_next = start_time;
    stop_time_next  = stop_time;
    if (restart) begin
      phase_next      = dcd_pkg::PH_IDLE;
      start_time_next = '0;
      stop_time_next  = '0;
    end else begin
      unique case (phase)
        dcd_pkg::PH_IDLE: begin
          if (loud) begin
            start_time_next = now;
            phase_next      = dcd_pkg::PH_FIRST_LOUD;
          end
        end
        dcd_pkg::PH_FIRST_LOUD, dcd_pkg::PH_SECOND_LOUD: begin
          if (quiet) begin
            stop_time_next = now;
            if (spike_span < TIME_BITS'(min_spike_time)) begin
              // too short: keep waiting for the real end
            end else if (spike_span > TIME_BITS'(max_spike_time)) begin
              phase_next = dcd_pkg::PH_IDLE;
            end else if (phase == dcd_pkg::PH_FIRST_LOUD) begin
              phase_next = dcd_pkg::PH_FIRST_QUIET;
            end else begin
              phase_next = dcd_pkg::PH_DONE;
            end
          end
        end
        dcd_pkg::PH_FIRST_QUIET: begin
          if (loud) begin
            start_time_next = now;
            if (gap_span < TIME_BITS'(min_gap_time)) begin
              // too short: stay quiet
            end else if (gap_span > TIME_BITS'(max_gap_time)) begin
              phase_next = dcd_pkg::PH_FIRST_LOUD;
            end else begin
              phase_next = dcd_pkg::PH_SECOND_LOUD;
            end
          end
        end
        dcd_pkg::PH_DONE: begin
          // hold until restart
        end
        default: phase_next = dcd_pkg::PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= dcd_pkg::PH_IDLE;
      start_time <= '0;
      stop_time  <= '0;
    end else if (step_en) begin
      phase      <= phase_next;
      start_time <= start_time_next;
      stop_time  <= stop_time_next;
    end
  end

`ifndef SYNTHESIS
  a_restart_idles: assert property (@(posedge clk) disable iff (rst)
    step_en && restart |=> phase == dcd_pkg::PH_IDLE)
    else $error("restart did not return the detector to idle");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    step_en && !restart && phase == dcd_pkg::PH_DONE |=> phase == dcd_pkg::PH_DONE)
    else $error("done phase left without a restart");

  a_phase_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(phase))
    else $error("phase register is not one-hot");
`endif

endmodule

>>> design/double_clap_detector.sv
// Top level of the double clap detector: stream ports, input and result registers, APB registers.
//
//  channel  | signals                      | word
//  ---------+------------------------------+------------------------------------------
//  s        | s_tvalid s_tready s_tdata    | tuser: action; tdata: sound_sample,
//           | s_tuser                      |   sample_time (low bits up), zero padded
//  m        | m_tvalid m_tready m_tdata    | tdata: finished, phase_code, zero padded
//  apb      | psel penable pwrite paddr    | five config registers at 4*index
//           | pwdata prdata pready         |
//
// An accepted input word is held in the input register while the phase update runs, and the
// result register loads from it on advance, once that register is free or being emptied.
// One item per cycle sustained while m_tready stays high; the phase update between input
// register and result register is combinational.
// Reset (rst, synchronous) empties both registers, returns the detector to idle and loads the
// register defaults. A stalled result holds in the result register while one more word can
// still be taken into the input register.
module double_clap_detector #(
  parameter  int SAMPLE_BITS = 12,
  parameter  int TIME_BITS   = 32,
  localparam int S_DATA_W    = ((SAMPLE_BITS + TIME_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // slave stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [S_DATA_W-1:0]           s_tdata,   // sound_sample, sample_time, zero padding
  input  logic                          s_tuser,   // action (1 = restart)
  // master stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // finished, phase_code[2:0], zero padding
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcd_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // Configuration registers
  logic [SAMPLE_BITS-1:0]        level_threshold;
  logic [dcd_pkg::SPAN_BITS-1:0] min_spike_time;
  logic [dcd_pkg::SPAN_BITS-1:0] max_spike_time;
  logic [dcd_pkg::SPAN_BITS-1:0] min_gap_time;
  logic [dcd_pkg::SPAN_BITS-1:0] max_gap_time;
  logic                          cfg_write;
  logic [2:0]                    reg_index;

  // Input register
  logic                          in_valid;
  logic                          in_action;
  logic [SAMPLE_BITS-1:0]        in_sample;
  logic [TIME_BITS-1:0]          in_time;

  logic                          advance;
  dcd_pkg::phase_t               phase_next;
  logic [2:0]                    code_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[dcd_pkg::ADDR_BITS-1:2];

  // Write the addressed register; drop writes beyond the map.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_threshold <= SAMPLE_BITS'(dcd_pkg::THRESHOLD_RESET);
      min_spike_time  <= dcd_pkg::MIN_SPIKE_RESET;
      max_spike_time  <= dcd_pkg::MAX_SPIKE_RESET;
      min_gap_time    <= dcd_pkg::MIN_GAP_RESET;
      max_gap_time    <= dcd_pkg::MAX_GAP_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        dcd_pkg::REG_SOUND_THRESHOLD: level_threshold <= pwdata[SAMPLE_BITS-1:0];
        dcd_pkg::REG_MIN_SPIKE_TIME:  min_spike_time  <= pwdata[dcd_pkg::SPAN_BITS-1:0];
        dcd_pkg::REG_MAX_SPIKE_TIME:  max_spike_time  <= pwdata[dcd_pkg::SPAN_BITS-1:0];
        dcd_pkg::REG_MIN_GAP_TIME:    min_gap_time    <= pwdata[dcd_pkg::SPAN_BITS-1:0];
        dcd_pkg::REG_MAX_GAP_TIME:    max_gap_time    <= pwdata[dcd_pkg::SPAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register; unmapped addresses read zero.
  always_comb begin
    unique case (reg_index)
      dcd_pkg::REG_SOUND_THRESHOLD: prdata = 32'(level_threshold);
      dcd_pkg::REG_MIN_SPIKE_TIME:  prdata = 32'(min_spike_time);
      dcd_pkg::REG_MAX_SPIKE_TIME:  prdata = 32'(max_spike_time);
      dcd_pkg::REG_MIN_GAP_TIME:    prdata = 32'(min_gap_time);
      dcd_pkg::REG_MAX_GAP_TIME:    prdata = 32'(max_gap_time);
      default:                      prdata = '0;
    endcase
  end

  // Advance the input word into the result register whenever that register is free
  // or being emptied this cycle.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Capture the payload on accept; no reset needed.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_sample <= s_tdata[SAMPLE_BITS-1:0];
      in_time   <= s_tdata[SAMPLE_BITS+TIME_BITS-1:SAMPLE_BITS];
    end
  end

  dcd_core #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .step_en        (advance),
    .restart        (in_action),
    .sample         (in_sample),
    .now            (in_time),
    .level_threshold(level_threshold),
    .min_spike_time (min_spike_time),
    .max_spike_time (max_spike_time),
    .min_gap_time   (min_gap_time),
    .max_gap_time   (max_gap_time),
    .phase_next     (phase_next)
  );

  assign code_next = dcd_pkg::phase_code(phase_next);

  // Result register: load on advance, hold while stalled, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {4'b0000, code_next, (phase_next == dcd_pkg::PH_DONE)};
    end
  end

`ifndef SYNTHESIS
  a_finished_matches_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == dcd_pkg::PHASE_CODE_DONE)))
    else $error("finished flag disagrees with phase code");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while both registers are full");

  a_result_holds_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed or vanished");
`endif

endmodule

>>> tb/double_clap_detector_test.sv
// Self-checking testbench for the double clap detector: stream words in, phase results out.
`timescale 1ns / 100ps

module double_clap_detector_test;

  localparam int WORD_BITS = 48;            // sound_sample[11:0], sample_time[43:12], padding
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam logic ACT_SAMPLE  = 1'b0;
  localparam logic ACT_RESTART = 1'b1;
  localparam logic [2:0] REG_UNMAPPED = 3'd5;

  typedef struct packed {
    logic       finished;
    logic [2:0] phase_code;
  } clap_result_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [WORD_BITS-1:0] s_tdata;   // sound_sample[11:0], sample_time[43:12], zeros
  logic                 s_tuser;   // action (1 = restart)
  logic                 m_tvalid;
  logic                 m_tready = 1'b1;
  logic [7:0]           m_tdata;   // finished[0], phase_code[3:1], zeros
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [dcd_pkg::ADDR_BITS-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  // Detector copy kept by the testbench, plus the register values it believes are loaded.
  logic [2:0]  det_phase;
  logic [31:0] det_start;
  logic [31:0] det_end;
  logic [11:0] cfg_threshold;
  logic [15:0] cfg_min_spike;
  logic [15:0] cfg_max_spike;
  logic [15:0] cfg_min_gap;
  logic [15:0] cfg_max_gap;

  clap_result_t expected_phases[$];
  clap_result_t oldest_result;
  int           mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  words_sent = 0;
  int unsigned  sender_idle_pct = 0;
  int unsigned  receiver_stall_pct = 0;

  double_clap_detector i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stall the result side at the rate of the current phase.
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch in %s at %0t: expected %0h, got %0h", what, $time, want, got);
  endtask

  // Compare every accepted result word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_phases.size() == 0) begin
        flag_mismatch("unexpected result word", 32'd0, {24'd0, m_tdata});
      end else begin
        oldest_result = expected_phases.pop_front();
        if (m_tdata[0] !== oldest_result.finished)
          flag_mismatch("finished", {31'd0, oldest_result.finished}, {31'd0, m_tdata[0]});
        if (m_tdata[3:1] !== oldest_result.phase_code)
          flag_mismatch("phase_code", {29'd0, oldest_result.phase_code}, {29'd0, m_tdata[3:1]});
      end
    end
  end

  // Advance the testbench copy of the detector by one word; return the result it causes.
  function automatic clap_result_t advance_detector(input logic restart, input logic [11:0] level,
                                                    input logic [31:0] stamp);
    logic         loud;
    logic         quiet;
    logic [31:0]  span;
    clap_result_t res;
    loud  = level > cfg_threshold;
    quiet = level < cfg_threshold;
    if (restart) begin
      det_phase = dcd_pkg::PHASE_CODE_IDLE;
      det_start = '0;
      det_end   = '0;
    end else begin
      case (det_phase)
        dcd_pkg::PHASE_CODE_IDLE: begin
          if (loud) begin
            det_start = stamp;
            det_phase = dcd_pkg::PHASE_CODE_FIRST_LOUD;
          end
        end
        dcd_pkg::PHASE_CODE_FIRST_LOUD, dcd_pkg::PHASE_CODE_SECOND_LOUD: begin
          if (quiet) begin
            det_end = stamp;
            span    = det_end - det_start;   // wraps modulo 2^32
            // a spike shorter than the minimum keeps the loud phase
            if (span >= {16'd0, cfg_min_spike}) begin
              if (span > {16'd0, cfg_max_spike})
                det_phase = dcd_pkg::PHASE_CODE_IDLE;
              else if (det_phase == dcd_pkg::PHASE_CODE_FIRST_LOUD)
                det_phase = dcd_pkg::PHASE_CODE_FIRST_QUIET;
              else
                det_phase = dcd_pkg::PHASE_CODE_DONE;
            end
          end
        end
        dcd_pkg::PHASE_CODE_FIRST_QUIET: begin
          if (loud) begin
            det_start = stamp;
            span      = det_start - det_end;
            // a gap shorter than the minimum keeps waiting in the quiet phase
            if (span >= {16'd0, cfg_min_gap}) begin
              if (span > {16'd0, cfg_max_gap})
                det_phase = dcd_pkg::PHASE_CODE_FIRST_LOUD;
              else
                det_phase = dcd_pkg::PHASE_CODE_SECOND_LOUD;
            end
          end
        end
        default: begin
          // done: hold until a restart word
        end
      endcase
    end
    res.finished   = (det_phase == dcd_pkg::PHASE_CODE_DONE);
    res.phase_code = det_phase;
    return res;
  endfunction

  // Send one word. Enter and leave at a falling edge; tvalid stays high on return so the
  // next word can follow back to back.
  task automatic send_word(input logic restart, input logic [11:0] level,
                           input logic [31:0] stamp);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = restart;
    s_tdata  = {4'd0, stamp, level};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_phases.push_back(advance_detector(restart, level, stamp));
    words_sent++;
    @(negedge clk);
  endtask

  // Drop tvalid and wait until every result is back, so the registers may change.
  task automatic settle_detector();
    s_tvalid = 1'b0;
    while (expected_phases.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_register(input logic [2:0] idx, input logic [31:0] want);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want)
      flag_mismatch($sformatf("register %0d read", idx), want, prdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Write one register, mirror it in the predictor and read it back.
  task automatic write_config(input logic [2:0] idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      dcd_pkg::REG_SOUND_THRESHOLD: cfg_threshold = value[11:0];
      dcd_pkg::REG_MIN_SPIKE_TIME:  cfg_min_spike = value[15:0];
      dcd_pkg::REG_MAX_SPIKE_TIME:  cfg_max_spike = value[15:0];
      dcd_pkg::REG_MIN_GAP_TIME:    cfg_min_gap   = value[15:0];
      dcd_pkg::REG_MAX_GAP_TIME:    cfg_max_gap   = value[15:0];
      default: ;   // unmapped index: nothing changes
    endcase
    case (idx)
      dcd_pkg::REG_SOUND_THRESHOLD: check_register(idx, {20'd0, cfg_threshold});
      dcd_pkg::REG_MIN_SPIKE_TIME:  check_register(idx, {16'd0, cfg_min_spike});
      dcd_pkg::REG_MAX_SPIKE_TIME:  check_register(idx, {16'd0, cfg_max_spike});
      dcd_pkg::REG_MIN_GAP_TIME:    check_register(idx, {16'd0, cfg_min_gap});
      dcd_pkg::REG_MAX_GAP_TIME:    check_register(idx, {16'd0, cfg_max_gap});
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [11:0] threshold, input logic [15:0] spike_lo,
                            input logic [15:0] spike_hi, input logic [15:0] gap_lo,
                            input logic [15:0] gap_hi);
    write_config(dcd_pkg::REG_SOUND_THRESHOLD, {20'd0, threshold});
    write_config(dcd_pkg::REG_MIN_SPIKE_TIME, {16'd0, spike_lo});
    write_config(dcd_pkg::REG_MAX_SPIKE_TIME, {16'd0, spike_hi});
    write_config(dcd_pkg::REG_MIN_GAP_TIME, {16'd0, gap_lo});
    write_config(dcd_pkg::REG_MAX_GAP_TIME, {16'd0, gap_hi});
  endtask

  function automatic logic [11:0] loud_level();
    if (cfg_threshold == 12'hFFF) return 12'hFFF;   // nothing can be louder
    return 12'($urandom_range(4095, 32'(cfg_threshold) + 1));
  endfunction

  function automatic logic [11:0] quiet_level();
    if (cfg_threshold == 12'd0) return 12'd0;       // nothing can be quieter
    return 12'($urandom_range(32'(cfg_threshold) - 1, 0));
  endfunction

  // Pick a duration at or next to the edges of [lo, hi] or inside it, now and then anywhere in 32 bits.
  function automatic logic [31:0] pick_span(input logic [15:0] lo, input logic [15:0] hi);
    case ($urandom_range(7))
      0: return {16'd0, lo} - 32'd1;
      1: return {16'd0, lo};
      2: return {16'd0, hi};
      3: return {16'd0, hi} + 32'd1;
      4: return $urandom();
      default: begin
        if (hi >= lo) return {16'd0, lo} + $urandom_range(32'(hi - lo));
        return $urandom_range(65535);
      end
    endcase
  endfunction

  // One clap pattern with random timing: loud, quiet, loud, quiet, with some extras.
  task automatic play_clap();
    logic [31:0] now;
    now = $urandom();
    if ($urandom_range(9) < 7) send_word(ACT_RESTART, 12'($urandom()), $urandom());
    send_word(ACT_SAMPLE, loud_level(), now);
    if ($urandom_range(3) == 0) send_word(ACT_SAMPLE, cfg_threshold, now + 32'd1);
    now += pick_span(cfg_min_spike, cfg_max_spike);
    send_word(ACT_SAMPLE, quiet_level(), now);
    now += pick_span(cfg_min_gap, cfg_max_gap);
    send_word(ACT_SAMPLE, loud_level(), now);
    if ($urandom_range(3) == 0) send_word(ACT_SAMPLE, loud_level(), now + 32'd2);
    now += pick_span(cfg_min_spike, cfg_max_spike);
    send_word(ACT_SAMPLE, quiet_level(), now);
    if ($urandom_range(3) == 0)
      send_word(ACT_SAMPLE, 12'($urandom()), now + $urandom_range(100));
  endtask

  // Mostly clap patterns, the rest loose words with random fields.
  task automatic run_claps(input int unsigned target);
    int unsigned first;
    first = words_sent;
    while (words_sent - first < target) begin
      if ($urandom_range(4) != 0) begin
        play_clap();
      end else begin
        repeat ($urandom_range(4, 1))
          send_word(($urandom_range(7) == 0), 12'($urandom()), $urandom());
      end
    end
  endtask

  task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  task automatic test_register_defaults();
    check_register(dcd_pkg::REG_SOUND_THRESHOLD, 32'(dcd_pkg::THRESHOLD_RESET));
    check_register(dcd_pkg::REG_MIN_SPIKE_TIME, {16'd0, dcd_pkg::MIN_SPIKE_RESET});
    check_register(dcd_pkg::REG_MAX_SPIKE_TIME, {16'd0, dcd_pkg::MAX_SPIKE_RESET});
    check_register(dcd_pkg::REG_MIN_GAP_TIME, {16'd0, dcd_pkg::MIN_GAP_RESET});
    check_register(dcd_pkg::REG_MAX_GAP_TIME, {16'd0, dcd_pkg::MAX_GAP_RESET});
  endtask

  // Walk the phases at the reset limits (threshold 2048, spike 10..200, gap 50..1000).
  task automatic test_directed_claps();
    send_word(ACT_SAMPLE, 12'd2048, 32'd10);           // level at threshold: idle holds
    send_word(ACT_SAMPLE, 12'd4095, 32'd100);          // first spike starts
    send_word(ACT_SAMPLE, 12'd2048, 32'd103);          // threshold level while loud
    send_word(ACT_SAMPLE, 12'd0, 32'd105);             // spike too short, stay loud
    send_word(ACT_SAMPLE, 12'd2047, 32'd150);          // valid spike: first quiet
    send_word(ACT_SAMPLE, 12'd2049, 32'd170);          // gap too short, stay quiet
    send_word(ACT_SAMPLE, 12'd2048, 32'd190);
    send_word(ACT_SAMPLE, 12'd3000, 32'd250);          // gap of 100 from 150: second loud
    send_word(ACT_SAMPLE, 12'd100, 32'd260);           // spike at minimum: done
    send_word(ACT_SAMPLE, 12'd4095, 32'd300);          // done ignores samples
    send_word(ACT_SAMPLE, 12'd0, 32'd400);
    send_word(ACT_RESTART, 12'hFFF, 32'hFFFF_FFFF);    // restart ignores its fields
    send_word(ACT_SAMPLE, 12'd4095, 32'hFFFF_FFF0);    // spike across the timer wrap
    send_word(ACT_SAMPLE, 12'd0, 32'h0000_00C0);       // too long: back to idle
    send_word(ACT_SAMPLE, 12'd4095, 32'hFFFF_FFFF);
    send_word(ACT_SAMPLE, 12'd0, 32'd199);             // spike at maximum: first quiet
    send_word(ACT_SAMPLE, 12'd4095, 32'd1199);         // gap at maximum: second loud
    send_word(ACT_SAMPLE, 12'd0, 32'd1400);            // second spike too long: idle
    send_word(ACT_SAMPLE, 12'd4095, 32'd0);
    send_word(ACT_SAMPLE, 12'd0, 32'd10);
    send_word(ACT_SAMPLE, 12'd4095, 32'd1011);         // gap too long: new first spike
    send_word(ACT_SAMPLE, 12'd0, 32'd1021);
    send_word(ACT_SAMPLE, 12'd4095, 32'd1071);         // gap at minimum: second loud
    send_word(ACT_RESTART, 12'd0, 32'd0);
    settle_detector();
  endtask

  // Extreme thresholds and windows, plus a write to an unmapped address.
  task automatic test_register_extremes();
    write_config(REG_UNMAPPED, $urandom());
    set_limits(12'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    run_claps(40);
    settle_detector();
    set_limits(12'hFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
    run_claps(40);
    settle_detector();
    set_limits(12'($urandom_range(4000, 100)), 16'd0, 16'd0, 16'd0, 16'd0);
    run_claps(40);
    settle_detector();
    set_limits(12'($urandom_range(4000, 100)), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_claps(30);
    settle_detector();
  endtask

  // Random limits, mostly narrow windows so the patterns get past the first phases.
  task automatic test_random_claps(input int unsigned sender_pct, input int unsigned receiver_pct);
    logic [15:0] lo;
    lo = 16'($urandom_range(100));
    write_config(dcd_pkg::REG_SOUND_THRESHOLD,
                 {20'($urandom()), 12'($urandom_range(3800, 300))});
    write_config(dcd_pkg::REG_MIN_SPIKE_TIME, {16'($urandom()), lo});
    write_config(dcd_pkg::REG_MAX_SPIKE_TIME, {16'd0, lo + 16'($urandom_range(300))});
    lo = 16'($urandom_range(300));
    write_config(dcd_pkg::REG_MIN_GAP_TIME, {16'd0, lo});
    write_config(dcd_pkg::REG_MAX_GAP_TIME, {16'($urandom()), lo + 16'($urandom_range(2000))});
    set_idling(sender_pct, receiver_pct);
    run_claps(440);
    settle_detector();
  endtask

  initial begin
    // Hold every input at a known value and keep the block in reset.
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    det_phase     = dcd_pkg::PHASE_CODE_IDLE;
    det_start     = '0;
    det_end       = '0;
    cfg_threshold = 12'(dcd_pkg::THRESHOLD_RESET);
    cfg_min_spike = dcd_pkg::MIN_SPIKE_RESET;
    cfg_max_spike = dcd_pkg::MAX_SPIKE_RESET;
    cfg_min_gap   = dcd_pkg::MIN_GAP_RESET;
    cfg_max_gap   = dcd_pkg::MAX_GAP_RESET;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_register_defaults();
    test_directed_claps();
    test_register_extremes();
    test_random_claps(0, 0);
    test_random_claps(75, 0);
    test_random_claps(0, 75);
    test_random_claps(21, 21);

    // settle_detector has drained every result; let the pipeline idle before the final check.
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_phases.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
